// ===== hdl/csp_pkg.sv =====
// csp_pkg: word types and register codes for the cylinder support point block
// no dependencies

package csp_pkg;

    localparam logic [7:0] REG_RADIUS      = 8'd0;
    localparam logic [7:0] REG_HALF_HEIGHT = 8'd1;

    localparam logic [30:0] RESET_RADIUS      = 31'd65536;
    localparam logic [30:0] RESET_HALF_HEIGHT = 31'd65536;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               batch_last_in;
    } dir_word_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               batch_last_out;
    } point_word_t;

    typedef struct packed {
        logic [62:0] num_x;
        logic [62:0] num_z;
        logic        neg_x;
        logic        neg_z;
        logic        neg_y;
        logic        last;
    } sq_side_t;

    typedef struct packed {
        logic s_zero;
        logic neg_x;
        logic neg_z;
        logic neg_y;
        logic last;
    } dv_side_t;

endpackage

// ===== hdl/cylinder_support_point.sv =====
// cylinder_support_point: top level, input and square stages, output stage
// depends on csp_pkg, csp_sqrt, csp_div
//
// Takes one direction word per cycle whenever start is high; busy stays low and a
// new word may follow every cycle. Each word gives one point word, flagged by done
// for one cycle, after 3 front stages, 32 root stages, 31 divide stages and 1
// output stage. Results keep input order and cannot be held off. Write radius and
// half_height only while no word is in flight.

module cylinder_support_point
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  dir_word_t   dir,
    output logic        done,
    output point_word_t point,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [30:0] radius_reg;
    logic [30:0] half_height_reg;

    dir_word_t   in_reg;
    logic        vld_a_reg;
    logic [31:0] mx;
    logic [31:0] mz;

    logic [63:0] sqx_reg;
    logic [63:0] sqz_reg;
    sq_side_t    side_b_reg;
    logic        vld_b_reg;

    logic [63:0] sum_reg;
    sq_side_t    side_c_reg;
    logic        vld_c_reg;

    logic        sq_vld;
    logic [31:0] sq_root;
    sq_side_t    sq_side;
    dv_side_t    dv_side_in;

    logic        dv_vld;
    logic [30:0] quo_x;
    logic [30:0] quo_z;
    dv_side_t    dv_side;

    logic        done_reg;
    point_word_t point_reg;
    point_word_t point_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= RESET_RADIUS;
            half_height_reg <= RESET_HALF_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RADIUS:      radius_reg      <= cfg_data[30:0];
                REG_HALF_HEIGHT: half_height_reg <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld_a_reg <= start && !busy;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            done_reg  <= dv_vld;
        end
    end

    // magnitudes, the most negative value maps to 2^31
    assign mx = in_reg.dir_x[31] ? 32'(-in_reg.dir_x) : 32'(in_reg.dir_x);
    assign mz = in_reg.dir_z[31] ? 32'(-in_reg.dir_z) : 32'(in_reg.dir_z);

    always_ff @(posedge clk)
    begin
        in_reg           <= dir;
        sqx_reg          <= 64'(mx) * 64'(mx);
        sqz_reg          <= 64'(mz) * 64'(mz);
        side_b_reg.num_x <= 63'(mx) * 63'(radius_reg);
        side_b_reg.num_z <= 63'(mz) * 63'(radius_reg);
        side_b_reg.neg_x <= in_reg.dir_x[31];
        side_b_reg.neg_z <= in_reg.dir_z[31];
        side_b_reg.neg_y <= in_reg.dir_y[31];
        side_b_reg.last  <= in_reg.batch_last_in;
        sum_reg          <= sqx_reg + sqz_reg;
        side_c_reg       <= side_b_reg;
        point_reg        <= point_next;
    end

    csp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (vld_c_reg),
        .val_in   (sum_reg),
        .side_in  (side_c_reg),
        .vld_out  (sq_vld),
        .root_out (sq_root),
        .side_out (sq_side)
    );

    always_comb
    begin
        dv_side_in.s_zero = (sq_root == 32'd0);
        dv_side_in.neg_x  = sq_side.neg_x;
        dv_side_in.neg_z  = sq_side.neg_z;
        dv_side_in.neg_y  = sq_side.neg_y;
        dv_side_in.last   = sq_side.last;
    end

    csp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld_in    (sq_vld),
        .num_x_in  (sq_side.num_x),
        .num_z_in  (sq_side.num_z),
        .den_in    (sq_root),
        .side_in   (dv_side_in),
        .vld_out   (dv_vld),
        .quo_x_out (quo_x),
        .quo_z_out (quo_z),
        .side_out  (dv_side)
    );

    always_comb
    begin
        if (dv_side.s_zero)
        begin
            point_next.point_x = {1'b0, radius_reg};
            point_next.point_z = 32'sd0;
        end
        else
        begin
            point_next.point_x = dv_side.neg_x ? -{1'b0, quo_x} : {1'b0, quo_x};
            point_next.point_z = dv_side.neg_z ? -{1'b0, quo_z} : {1'b0, quo_z};
        end
        point_next.point_y = dv_side.neg_y ? -{1'b0, half_height_reg}
                                           : {1'b0, half_height_reg};
        point_next.batch_last_out = dv_side.last;
    end

    assign done  = done_reg;
    assign point = point_reg;

endmodule

// ===== hdl/csp_sqrt.sv =====
// csp_sqrt: pipelined integer square root, one root bit per stage
// depends on csp_pkg

module csp_sqrt
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vld_in,
    input  logic [63:0] val_in,
    input  sq_side_t    side_in,
    output logic        vld_out,
    output logic [31:0] root_out,
    output sq_side_t    side_out
);

    localparam int Stages = 32;

    logic [63:0] rem_reg [0:Stages];
    logic [63:0] res_reg [0:Stages];
    logic        vld_reg [0:Stages];
    sq_side_t    side_reg [0:Stages];

    always_comb
    begin
        rem_reg[0]  = val_in;
        res_reg[0]  = 64'd0;
        vld_reg[0]  = vld_in;
        side_reg[0] = side_in;
    end

    for (genvar k = 0; k < Stages; k++)
    begin : g_stage
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        always_comb
        begin
            trial = res_reg[k] + Bit;
            if (rem_reg[k] >= trial)
            begin
                rem_next = rem_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + Bit;
            end
            else
            begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k + 1] <= 1'b0;
            end
            else
            begin
                vld_reg[k + 1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k + 1]  <= rem_next;
            res_reg[k + 1]  <= res_next;
            side_reg[k + 1] <= side_reg[k];
        end
    end

    assign vld_out  = vld_reg[Stages];
    assign root_out = res_reg[Stages][31:0];
    assign side_out = side_reg[Stages];

endmodule

// ===== hdl/csp_div.sv =====
// csp_div: twin pipelined restoring dividers sharing one divisor
// depends on csp_pkg

module csp_div
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vld_in,
    input  logic [62:0] num_x_in,
    input  logic [62:0] num_z_in,
    input  logic [31:0] den_in,
    input  dv_side_t    side_in,
    output logic        vld_out,
    output logic [30:0] quo_x_out,
    output logic [30:0] quo_z_out,
    output dv_side_t    side_out
);

    localparam int Stages = 31;

    logic [62:0] rx_reg [0:Stages];
    logic [62:0] rz_reg [0:Stages];
    logic [30:0] qx_reg [0:Stages];
    logic [30:0] qz_reg [0:Stages];
    logic [31:0] den_reg [0:Stages];
    logic        vld_reg [0:Stages];
    dv_side_t    side_reg [0:Stages];

    always_comb
    begin
        rx_reg[0]   = num_x_in;
        rz_reg[0]   = num_z_in;
        qx_reg[0]   = 31'd0;
        qz_reg[0]   = 31'd0;
        den_reg[0]  = den_in;
        vld_reg[0]  = vld_in;
        side_reg[0] = side_in;
    end

    for (genvar j = 0; j < Stages; j++)
    begin : g_stage
        localparam int Sh = Stages - 1 - j;
        logic [62:0] dsh;
        logic [62:0] rx_next;
        logic [62:0] rz_next;
        logic [30:0] qx_next;
        logic [30:0] qz_next;

        always_comb
        begin
            dsh     = 63'(den_reg[j]) << Sh;
            rx_next = rx_reg[j];
            rz_next = rz_reg[j];
            qx_next = qx_reg[j];
            qz_next = qz_reg[j];
            if (rx_reg[j] >= dsh)
            begin
                rx_next     = rx_reg[j] - dsh;
                qx_next[Sh] = 1'b1;
            end
            if (rz_reg[j] >= dsh)
            begin
                rz_next     = rz_reg[j] - dsh;
                qz_next[Sh] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j + 1] <= 1'b0;
            end
            else
            begin
                vld_reg[j + 1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rx_reg[j + 1]   <= rx_next;
            rz_reg[j + 1]   <= rz_next;
            qx_reg[j + 1]   <= qx_next;
            qz_reg[j + 1]   <= qz_next;
            den_reg[j + 1]  <= den_reg[j];
            side_reg[j + 1] <= side_reg[j];
        end
    end

    assign vld_out   = vld_reg[Stages];
    assign quo_x_out = qx_reg[Stages];
    assign quo_z_out = qz_reg[Stages];
    assign side_out  = side_reg[Stages];

endmodule

// ===== hdl/csp_checker.sv =====
// csp_checker: port-level checks for cylinder_support_point, with its bind
// depends on csp_pkg and cylinder_support_point

module csp_checker
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  dir_word_t   dir,
    input  logic        done,
    input  point_word_t point
);

    localparam int Latency = 67;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Latency))
        else $error("result word without a start");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> point.batch_last_out == $past(dir.batch_last_in, Latency))
        else $error("batch flag out of step");

    a_zero_xz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(dir.dir_x == 32'sd0 && dir.dir_z == 32'sd0, Latency))
            |-> point.point_z == 32'sd0)
        else $error("zero x-z direction gave nonzero z");

endmodule

bind cylinder_support_point csp_checker u_csp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .dir   (dir),
    .done  (done),
    .point (point)
);
